@@ design/nses_pkg.sv @@
// nses_pkg: shared types and constants for the noise estimate / spectral subtract block
// word structs for both channels, register index codes and fixed-point constants
// no dependencies
package nses_pkg;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               frame_start;
  } item_t;

  typedef struct packed {
    logic signed [23:0] sample_out;
    logic [23:0]        gain;
  } result_t;

  typedef enum logic [2:0] {
    REG_NOISE_MODE,
    REG_SUBTRACT_MODE,
    REG_OVER_SUBTRACT,
    REG_PEAK_ATTACK,
    REG_PEAK_RELEASE,
    REG_VALLEY_ATTACK,
    REG_VALLEY_RISE,
    REG_NOISE_AVG_COEF
  } cfg_reg_t;

  typedef enum logic [1:0] {
    NM_HOLD,
    NM_SLEW,
    NM_GATED,
    NM_MCRA
  } noise_mode_t;

  localparam logic [24:0] ONE_Q24  = 25'h1000000;
  localparam logic [23:0] HALF_Q24 = 24'h800000;
  localparam logic [23:0] M24      = 24'hFFFFFF;
  localparam logic [22:0] M23      = 23'h7FFFFF;
  localparam logic [45:0] M46      = {46{1'b1}};
  localparam logic [46:0] EPS_Q46  = 47'd70368744;

endpackage

@@ design/nses_div.sv @@
// nses_div: restoring divider giving a 24-bit fractional quotient num/den, num < den
// one quotient bit per cycle; does not use nses_pkg
// no dependencies
module nses_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [46:0] num,
  input  logic [46:0] den,
  output logic        done,
  output logic [23:0] quo
);

  localparam int QW = 24;

  logic [46:0]          rem;
  logic [46:0]          dvs;
  logic [$clog2(QW):0]  cnt;
  logic                 busy;
  logic [47:0]          shifted;
  logic                 fits;

  // trial subtract of the doubled remainder
  assign shifted = {rem, 1'b0};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= num;
        dvs  <= den;
        quo  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        rem <= fits ? 47'(shifted - {1'b0, dvs}) : shifted[46:0];
        quo <= {quo[QW-2:0], fits};
        if (cnt == ($clog2(QW)+1)'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

@@ design/noise_estimate_spectral_subtract.sv @@
// noise_estimate_spectral_subtract: envelope tracking, noise power estimate and subtraction gain
// one word in, one word out; the next word is taken in the cycle after the result goes
// the shortest is a frame start in pass through; the longest is the mcra mode with a gain
// division: five blends on the shared 24x25 multiplier plus a division in nses_div
// synchronous active-high reset restores register defaults, clears the envelopes, the noise
// estimate and the seeded flag, and sets the speech probability to one half
// depends on nses_pkg and nses_div
module noise_estimate_spectral_subtract #(
  parameter logic [24:0] RISE_LIMIT       = 25'd16778423,
  parameter logic [23:0] FALL_LIMIT       = 24'd16774198,
  parameter logic [23:0] PROB_SMOOTH      = 24'd16672675,
  parameter logic [23:0] NOISE_SMOOTH_MIN = 24'd16771974,
  parameter logic [6:0]  SPEECH_RATIO     = 7'd10,
  parameter logic [4:0]  NOISE_GATE_RATIO = 5'd2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  nses_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output nses_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [24:0]       cfg_data
);
  import nses_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_SEEDSQ, S_PEAKW, S_VALW, S_PWSQ, S_VPSQ,
    S_UPW, S_DNW, S_SPW, S_BW, S_NOISEW,
    S_B0, S_B1, S_B2, S_B3, S_B4,
    S_SUB0, S_SUB1, S_SUB2, S_SUB3, S_DIV, S_SCALE0, S_SCALE1, S_OUT
  } state_t;

  typedef struct packed {
    logic [46:0] a;
    logic [46:0] b;
    logic [24:0] c;
    logic [24:0] d;
  } bop_t;

  localparam logic [24:0] NSM_COMP = ONE_Q24 - {1'b0, NOISE_SMOOTH_MIN};

  // blend operands: c clamped to one and d = 1 - c, or plain scaling with d unused
  function automatic bop_t mk_bop(input logic [46:0] a, input logic [46:0] b,
                                  input logic [24:0] c, input logic clamp);
    bop_t        op;
    logic [24:0] cc;
    cc   = (clamp && (c > ONE_Q24)) ? ONE_Q24 : c;
    op.a = a;
    op.b = clamp ? b : '0;
    op.c = cc;
    op.d = clamp ? 25'(ONE_Q24 - cc) : '0;
    return op;
  endfunction

  // configuration registers
  logic [1:0]  noise_mode;
  logic        subtract_mode;
  logic [15:0] over_subtract;
  logic [23:0] peak_attack, peak_release, valley_attack, noise_avg_coef;
  logic [24:0] valley_rise;

  // estimator state and work registers
  state_t      state, ret;
  logic [22:0] peak, valley, mag;
  logic [45:0] noise, pw;
  logic [23:0] sprob, raw, abs_raw, g;
  logic        seeded, neg, fs;
  bop_t        bop;
  logic [49:0] acc_hi, bres, up;
  logic [48:0] acc_lo;
  logic [37:0] sub_hi;
  logic [50:0] subv;
  logic        div_start, div_done;
  logic [46:0] div_num, div_den;
  logic [23:0] quo;
  result_t     res_q;

  // shared multiplier
  logic [23:0] mul_a;
  logic [24:0] mul_b;
  logic [48:0] prod;

  // combinational helpers
  logic [24:0] abs_in;
  logic [50:0] lo_sum;
  logic [62:0] sub_full;
  logic [46:0] den_c;
  logic [45:0] n1;
  logic [23:0] sp_sat;
  logic [49:0] rsum;
  logic [23:0] r24;

  assign cfg_ready    = 1'b1;
  assign item_stall   = (state != S_IDLE);
  assign result_valid = (state == S_OUT);
  assign result       = res_q;

  assign abs_in   = item.sample[23] ? 25'(ONE_Q24 - {1'b0, item.sample}) : {1'b0, item.sample};
  assign lo_sum   = 51'(acc_lo) + 51'(prod) + 51'(HALF_Q24);
  assign sub_full = {1'b0, sub_hi, 24'b0} + 63'(prod) + 63'd2048;
  assign den_c    = 47'(prod[45:0]) + EPS_Q46;
  assign n1       = ({4'b0, pw} < up) ? pw : up[45:0];
  assign sp_sat   = (bres > 50'(M24)) ? M24 : bres[23:0];
  assign rsum     = 50'(prod) + 50'(HALF_Q24);
  assign r24      = rsum[47:24];

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_START:  begin mul_a = {1'b0, mag};           mul_b = {2'b0, mag};        end
      S_VALW:   begin mul_a = {1'b0, peak};          mul_b = {2'b0, peak};       end
      S_PWSQ:   begin mul_a = {1'b0, valley};        mul_b = {2'b0, valley};     end
      S_B0:     begin mul_a = {1'b0, bop.a[46:24]};  mul_b = bop.c;              end
      S_B1:     begin mul_a = bop.a[23:0];           mul_b = bop.c;              end
      S_B2:     begin mul_a = {1'b0, bop.b[46:24]};  mul_b = bop.d;              end
      S_B3:     begin mul_a = bop.b[23:0];           mul_b = bop.d;              end
      S_SUB0:   begin mul_a = {2'b0, noise[45:24]};  mul_b = {9'b0, over_subtract}; end
      S_SUB1:   begin mul_a = noise[23:0];           mul_b = {9'b0, over_subtract}; end
      S_SUB2:   begin mul_a = {1'b0, peak};          mul_b = {2'b0, peak};       end
      S_SCALE0: begin mul_a = abs_raw;               mul_b = {1'b0, g};          end
      default:  begin mul_a = '0;                    mul_b = '0;                 end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 49'(mul_a * mul_b);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_mode     <= 2'd1;
      subtract_mode  <= 1'b1;
      over_subtract  <= 16'd4096;
      peak_attack    <= 24'd16431302;
      peak_release   <= 24'd16756261;
      valley_attack  <= 24'd16672675;
      valley_rise    <= 25'd16787703;
      noise_avg_coef <= 24'd16766733;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_NOISE_MODE:     noise_mode     <= cfg_data[1:0];
        REG_SUBTRACT_MODE:  subtract_mode  <= cfg_data[0];
        REG_OVER_SUBTRACT:  over_subtract  <= cfg_data[15:0];
        REG_PEAK_ATTACK:    peak_attack    <= cfg_data[23:0];
        REG_PEAK_RELEASE:   peak_release   <= cfg_data[23:0];
        REG_VALLEY_ATTACK:  valley_attack  <= cfg_data[23:0];
        REG_VALLEY_RISE:    valley_rise    <= cfg_data;
        REG_NOISE_AVG_COEF: noise_avg_coef <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      seeded    <= 1'b0;
      peak      <= '0;
      valley    <= '0;
      noise     <= '0;
      sprob     <= HALF_Q24;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            raw     <= item.sample;
            neg     <= item.sample[23];
            fs      <= item.frame_start;
            abs_raw <= abs_in[23:0];
            mag     <= (abs_in > 25'(M23)) ? M23 : abs_in[22:0];
            state   <= S_START;
          end
        end
        // first word seeds the envelopes and the noise estimate, later frame starts leave state alone
        S_START: begin
          if (!seeded) begin
            peak   <= mag;
            valley <= mag;
            seeded <= 1'b1;
            state  <= S_SEEDSQ;
          end else if (!fs) begin
            if (mag >= peak)
              bop <= mk_bop({24'b0, peak}, {24'b0, mag}, {1'b0, peak_attack}, 1'b1);
            else
              bop <= mk_bop({24'b0, peak}, '0, {1'b0, peak_release}, 1'b0);
            ret   <= S_PEAKW;
            state <= S_B0;
          end else begin
            state <= S_SUB0;
          end
        end
        S_SEEDSQ: begin
          noise <= prod[45:0];
          state <= S_SUB0;
        end
        S_PEAKW: begin
          peak <= bres[22:0];
          if (mag <= valley)
            bop <= mk_bop({24'b0, valley}, {24'b0, mag}, {1'b0, valley_attack}, 1'b1);
          else
            bop <= mk_bop({24'b0, valley}, '0, valley_rise, 1'b0);
          ret   <= S_VALW;
          state <= S_B0;
        end
        S_VALW: begin
          valley <= (bres > 50'(M23)) ? M23 : bres[22:0];
          state  <= S_PWSQ;
        end
        S_PWSQ: begin
          pw    <= prod[45:0];
          state <= S_VPSQ;
        end
        // noise estimate by mode, valley power straight off the multiplier
        S_VPSQ: begin
          case (noise_mode_t'(noise_mode))
            NM_SLEW: begin
              bop   <= mk_bop({1'b0, noise}, '0, RISE_LIMIT, 1'b0);
              ret   <= S_UPW;
              state <= S_B0;
            end
            NM_GATED: begin
              if (51'(pw) < 51'(noise) * 51'(NOISE_GATE_RATIO)) begin
                bop   <= mk_bop({1'b0, noise}, {1'b0, pw}, {1'b0, noise_avg_coef}, 1'b1);
                ret   <= S_NOISEW;
                state <= S_B0;
              end else begin
                state <= S_SUB0;
              end
            end
            NM_MCRA: begin
              bop <= mk_bop({23'b0, sprob},
                            (53'(pw) > 53'(prod[45:0]) * 53'(SPEECH_RATIO)) ?
                              47'(ONE_Q24) : 47'd0,
                            {1'b0, PROB_SMOOTH}, 1'b1);
              ret   <= S_SPW;
              state <= S_B0;
            end
            default: state <= S_SUB0;
          endcase
        end
        S_UPW: begin
          up    <= bres;
          bop   <= mk_bop({1'b0, noise}, '0, {1'b0, FALL_LIMIT}, 1'b0);
          ret   <= S_DNW;
          state <= S_B0;
        end
        S_DNW: begin
          noise <= (50'(n1) > bres) ? n1 : bres[45:0];
          state <= S_SUB0;
        end
        S_SPW: begin
          sprob <= sp_sat;
          bop   <= mk_bop(47'(NSM_COMP), '0, {1'b0, sp_sat}, 1'b0);
          ret   <= S_BW;
          state <= S_B0;
        end
        S_BW: begin
          bop   <= mk_bop({1'b0, noise}, {1'b0, pw},
                          25'({1'b0, NOISE_SMOOTH_MIN} + bres[24:0]), 1'b1);
          ret   <= S_NOISEW;
          state <= S_B0;
        end
        S_NOISEW: begin
          noise <= (bres > 50'(M46)) ? M46 : bres[45:0];
          state <= S_SUB0;
        end
        // blend: four partial products, one rounding
        S_B0: state <= S_B1;
        S_B1: begin
          acc_hi <= 50'(prod);
          state  <= S_B2;
        end
        S_B2: begin
          acc_lo <= prod;
          state  <= S_B3;
        end
        S_B3: begin
          acc_hi <= acc_hi + 50'(prod);
          state  <= S_B4;
        end
        S_B4: begin
          bres  <= acc_hi + 50'(lo_sum[50:24]);
          state <= ret;
        end
        // oversubtracted noise and gain, or pass through when subtraction is off
        S_SUB0: begin
          if (!subtract_mode) begin
            res_q.sample_out <= raw;
            res_q.gain       <= M24;
            state            <= S_OUT;
          end else begin
            state <= S_SUB1;
          end
        end
        S_SUB1: begin
          sub_hi <= prod[37:0];
          state  <= S_SUB2;
        end
        S_SUB2: begin
          subv  <= sub_full[62:12];
          state <= S_SUB3;
        end
        S_SUB3: begin
          if (51'(den_c) <= subv) begin
            res_q.sample_out <= '0;
            res_q.gain       <= '0;
            state            <= S_OUT;
          end else if (subv == '0) begin
            g     <= M24;
            state <= S_SCALE0;
          end else begin
            div_num   <= den_c - subv[46:0];
            div_den   <= den_c;
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            g     <= quo;
            state <= S_SCALE0;
          end
        end
        S_SCALE0: state <= S_SCALE1;
        S_SCALE1: begin
          res_q.sample_out <= neg ? (24'd0 - r24) : r24;
          res_q.gain       <= g;
          state            <= S_OUT;
        end
        S_OUT: begin
          if (!result_stall)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  nses_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

endmodule

@@ design/nses_chk.sv @@
// nses_chk: port-level checks for noise_estimate_spectral_subtract, bound to the top level
// depends on nses_pkg for the word types
module nses_chk (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input nses_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input nses_pkg::result_t result,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [2:0]        cfg_index,
  input logic [24:0]       cfg_data
);
  import nses_pkg::*;

  // no new word while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall) else $error("word taken while result pending");

  // result_valid stays low just after a word is taken
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> !result_valid) else $error("result too early");

  // zero gain means a silent output word
  a_zero_gain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.gain == '0) |-> result.sample_out == '0)
    else $error("non-zero output at zero gain");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid) else $error("result after reset");

endmodule

bind noise_estimate_spectral_subtract nses_chk u_nses_chk (.*);
